/* rtl/twt_pkg.sv */
// ----------------------------------------------------------------------------
// twt_pkg
// Types, codes and byte classes shared by the text word tokenizer.
// ----------------------------------------------------------------------------
package twt_pkg;

    typedef enum logic [1:0] {
        KIND_WORD = 2'd0,
        KIND_SENT = 2'd1,
        KIND_FILE = 2'd2
    } kind_t;

    typedef struct packed {
        logic       tag_open;
        logic       in_section;
        logic [3:0] tag_pos;
        logic [2:0] tag_flags;
        logic [1:0] word_len;
        logic [7:0] held_byte;
        logic       last_sent;
    } state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] word_byte;
        logic       word_first;
        logic       word_last;
        logic       last_of_run;
    } result_t;

    localparam state_t STATE_RESET = '{
        tag_open:   1'b0,
        in_section: 1'b0,
        tag_pos:    4'd0,
        tag_flags:  3'b111,
        word_len:   2'd0,
        held_byte:  8'd0,
        last_sent:  1'b0
    };

    localparam logic [7:0] CHAR_LT = 8'h3C;
    localparam logic [7:0] CHAR_GT = 8'h3E;

    function automatic logic is_sep(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h22, 8'h28, 8'h29, 8'h3A, 8'h2B, 8'h2C,
                         8'h3B, 8'h27, 8'h2A, 8'd160, 8'd133, 8'd132, 8'd171,
                         8'd187};
    endfunction

    function automatic logic is_stop(input logic [7:0] c);
        return c inside {8'h2E, 8'h21, 8'h3F};
    endfunction

    function automatic logic is_dash(input logic [7:0] c);
        return c inside {8'h2D, 8'd151, 8'd150};
    endfunction

    // tag names: 0 = "/p", 1 = "section", 2 = "/section"
    function automatic logic [3:0] cand_len(input logic [1:0] idx);
        logic [3:0] len;
        case (idx)
            2'd0:    len = 4'd2;
            2'd1:    len = 4'd7;
            2'd2:    len = 4'd8;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] cand_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] c;
        case ({idx, pos})
            {2'd0, 3'd0}: c = "/";
            {2'd0, 3'd1}: c = "p";
            {2'd1, 3'd0}: c = "s";
            {2'd1, 3'd1}: c = "e";
            {2'd1, 3'd2}: c = "c";
            {2'd1, 3'd3}: c = "t";
            {2'd1, 3'd4}: c = "i";
            {2'd1, 3'd5}: c = "o";
            {2'd1, 3'd6}: c = "n";
            {2'd2, 3'd0}: c = "/";
            {2'd2, 3'd1}: c = "s";
            {2'd2, 3'd2}: c = "e";
            {2'd2, 3'd3}: c = "c";
            {2'd2, 3'd4}: c = "t";
            {2'd2, 3'd5}: c = "i";
            {2'd2, 3'd6}: c = "o";
            {2'd2, 3'd7}: c = "n";
            default:      c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/twt_step.sv */
// ----------------------------------------------------------------------------
// twt_step
// Next state and up to two results for one input item.
// ----------------------------------------------------------------------------
module twt_step
    import twt_pkg::*;
(
    input  state_t          st_i,
    input  logic            tagged_mode,
    input  logic [7:0]      text_byte,
    input  logic            is_line_end,
    input  logic            is_file_end,
    output state_t          st_o,
    output result_t [1:0]   res_o,
    output logic [1:0]      res_cnt_o
);

    logic       intag;
    logic       kept;
    logic       ew_emit;
    logic       ew_ls;
    logic       sect;
    logic [7:0] lb;
    logic [2:0] hit;
    logic       a_v;
    logic       b_v;
    result_t    a;
    result_t    b;
    state_t     nx;

    assign intag = tagged_mode && st_i.tag_open;
    assign kept  = !tagged_mode || st_i.in_section;
    assign sect  = tagged_mode && st_i.in_section;
    assign ew_emit = (st_i.word_len != 2'd0) &&
                     !((st_i.word_len == 2'd1) && is_dash(st_i.held_byte)) && kept;
    assign ew_ls = ew_emit ? 1'b0 : st_i.last_sent;
    assign lb = (text_byte inside {[8'h41:8'h5A]}) ? text_byte + 8'd32 : text_byte;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            hit[i] = st_i.tag_flags[i] && (st_i.tag_pos == cand_len(2'(i)));
        end
    end

    always_comb begin
        nx  = st_i;
        a_v = 1'b0;
        b_v = 1'b0;
        a   = '{kind: KIND_WORD, word_byte: st_i.held_byte,
                word_first: (st_i.word_len == 2'd1), word_last: 1'b1, last_of_run: 1'b0};
        b   = '{kind: KIND_SENT, word_byte: 8'd0, word_first: 1'b0, word_last: 1'b0,
                last_of_run: 1'b0};
        if (is_file_end) begin
            a_v    = !intag && ew_emit;
            b.kind = KIND_FILE;
            b_v    = 1'b1;
            nx     = STATE_RESET;
        end else if (is_line_end) begin
            if (intag) begin
                nx.tag_flags = 3'b000;
            end else begin
                a_v          = ew_emit;
                nx.word_len  = 2'd0;
                nx.last_sent = ew_ls;
            end
        end else if (intag) begin
            if (text_byte == CHAR_GT) begin
                if (st_i.in_section && hit[0]) begin
                    b_v          = !st_i.last_sent;
                    nx.last_sent = 1'b1;
                end else if (hit[1]) begin
                    nx.in_section = 1'b1;
                end else if (hit[2]) begin
                    nx.in_section = 1'b0;
                end
                nx.tag_open = 1'b0;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    if (st_i.tag_pos >= cand_len(2'(i)) ||
                        cand_char(2'(i), st_i.tag_pos[2:0]) != lb) begin
                        nx.tag_flags[i] = 1'b0;
                    end
                end
                if (st_i.tag_pos != 4'd15) begin
                    nx.tag_pos = st_i.tag_pos + 4'd1;
                end
            end
        end else if (is_sep(text_byte)) begin
            a_v          = ew_emit;
            nx.word_len  = 2'd0;
            nx.last_sent = ew_ls;
        end else if (is_stop(text_byte)) begin
            a_v          = ew_emit;
            nx.word_len  = 2'd0;
            b_v          = sect && !ew_ls;
            nx.last_sent = sect ? 1'b1 : ew_ls;
        end else if (tagged_mode && text_byte == CHAR_LT) begin
            a_v          = ew_emit;
            nx.word_len  = 2'd0;
            nx.last_sent = ew_ls;
            nx.tag_open  = 1'b1;
            nx.tag_pos   = 4'd0;
            nx.tag_flags = 3'b111;
        end else begin
            if (st_i.word_len != 2'd0 && kept) begin
                a_v          = 1'b1;
                a.word_last  = 1'b0;
                nx.last_sent = 1'b0;
            end
            nx.held_byte = text_byte;
            if (st_i.word_len != 2'd3) begin
                nx.word_len = st_i.word_len + 2'd1;
            end
        end
    end

    always_comb begin
        res_o[0] = a_v ? a : b;
        res_o[1] = b;
        res_cnt_o = {1'b0, a_v} + {1'b0, b_v};
        if (a_v && b_v) begin
            res_o[1].last_of_run = 1'b1;
        end else begin
            res_o[0].last_of_run = 1'b1;
        end
    end

    assign st_o = nx;

endmodule

/* rtl/twt_out_fifo.sv */
// ----------------------------------------------------------------------------
// twt_out_fifo
// Result queue: takes up to two items per cycle, hands out one per cycle while rd_ready is high.
// ----------------------------------------------------------------------------
module twt_out_fifo
    import twt_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      wr_n,
    input  result_t [1:0]   wr_data,
    output logic            room2,
    output logic            rd_valid,
    input  logic            rd_ready,
    output result_t         rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t        mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [PW-1:0]  wr_ptr1;
    logic           pop;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wr_ptr1  = inc(wr_ptr_reg);
    assign rd_valid = (count_reg != '0);
    assign pop      = rd_valid && rd_ready;
    assign room2    = (count_reg <= CW'(DEPTH - 2));
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_n != 2'd0) begin
            mem[wr_ptr_reg] <= wr_data[0];
        end
        if (wr_n == 2'd2) begin
            mem[wr_ptr1] <= wr_data[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_n == 2'd1) begin
                wr_ptr_reg <= wr_ptr1;
            end else if (wr_n == 2'd2) begin
                wr_ptr_reg <= inc(wr_ptr1);
            end
            if (pop) begin
                rd_ptr_reg <= inc(rd_ptr_reg);
            end
            count_reg <= count_reg + CW'(wr_n) - CW'(pop);
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH)) else $error("result queue count past depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_n != 2'd0) |-> room2) else $error("result queue written without room");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_n == 2'd2 && !pop) |=> count_reg == $past(count_reg) + CW'(2))
        else $error("result queue count lost a double write");

endmodule

/* rtl/text_word_tokenizer.sv */
// ----------------------------------------------------------------------------
// text_word_tokenizer
// Splits a byte stream into word bytes, sentence ends and file end.
//
//   channel | direction | payload
//   cfg     | in        | cfg_tagged_mode
//   s       | in        | s_text_byte, s_is_line_end, s_is_file_end
//   m       | out       | m_event_kind, m_word_byte, m_word_first, m_word_last,
//           |           | m_last_of_run
//
// One input item per cycle while s_ready is high; its zero to two results
// enter the result queue at the accepting edge and leave one per cycle, so
// output draining sets rate. s_ready is high while the queue has room for
// two items. Reset clears scan state, tagged mode and the queue; tagged
// mode survives file end. Configuration is always ready.
// ----------------------------------------------------------------------------
module text_word_tokenizer
    import twt_pkg::*;
#(
    parameter int OUT_DEPTH = 4
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_tagged_mode,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_is_line_end,
    input  logic        s_is_file_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [7:0]  m_word_byte,
    output logic        m_word_first,
    output logic        m_word_last,
    output logic        m_last_of_run
);

    state_t         state_reg;
    state_t         state_next;
    logic           tagged_mode_reg;
    result_t [1:0]  res;
    logic [1:0]     res_cnt;
    logic           accept;
    result_t        head;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    twt_step u_step (
        .st_i        (state_reg),
        .tagged_mode (tagged_mode_reg),
        .text_byte   (s_text_byte),
        .is_line_end (s_is_line_end),
        .is_file_end (s_is_file_end),
        .st_o        (state_next),
        .res_o       (res),
        .res_cnt_o   (res_cnt)
    );

    twt_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_n     (accept ? res_cnt : 2'd0),
        .wr_data  (res),
        .room2    (s_ready),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_data  (head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= STATE_RESET;
            tagged_mode_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready) begin
                tagged_mode_reg <= cfg_tagged_mode;
            end
        end
    end

    assign m_event_kind  = head.kind;
    assign m_word_byte   = head.word_byte;
    assign m_word_first  = head.word_first;
    assign m_word_last   = head.word_last;
    assign m_last_of_run = head.last_of_run;

    a_plain_no_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !tagged_mode_reg && res_cnt != 2'd0) |->
        (res[0].kind != KIND_SENT && res[1].kind != KIND_SENT || res_cnt == 2'd1 &&
         res[0].kind != KIND_SENT)) else $error("sentence end in plain mode");

    a_file_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_is_file_end) |=> (state_reg == STATE_RESET))
        else $error("state not cleared after file end");

    a_plain_no_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !tagged_mode_reg && !state_reg.tag_open) |=> !state_reg.tag_open)
        else $error("tag opened in plain mode");

endmodule
